### src/vnc_pkg.sv
// Shared types and constants for the version number comparator.
`timescale 1ns / 1ps

package vnc_pkg;

    localparam int unsigned PART_W = 31;
    localparam int unsigned VERDICT_W = 3;
    localparam logic [PART_W+3:0] PART_LIMIT = 35'd2147483647;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        OP_CHAR_FIRST  = 2'd0,
        OP_CHAR_SECOND = 2'd1,
        OP_END_FIRST   = 2'd2,
        OP_END_SECOND  = 2'd3
    } t_op;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_FIRST     = 3'd0,
        VERDICT_SECOND    = 3'd1,
        VERDICT_EQUAL     = 3'd2,
        VERDICT_EMPTY     = 3'd3,
        VERDICT_MALFORMED = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        DEC_NONE   = 2'd0,
        DEC_FIRST  = 2'd1,
        DEC_SECOND = 2'd2
    } t_decision;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_CMP  = 1'b1
    } t_state;

endpackage

### src/vnc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module vnc_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/version_number_compare.sv
// Top level of the dotted version number comparator.
`timescale 1ns / 1ps

//  channel   | valid    | stall    | payload
//  ----------+----------+----------+--------------------------
//  request   | i_valid  | o_stall  | i_op, i_char_code
//  verdict   | o_valid  | i_stall  | o_verdict
//
//  A dot in the second string and the end of a nonempty second string go
//  through ST_CMP: the stored component is read from the part RAM when the
//  request is taken and compared in ST_CMP, while further requests stall.
//  Reset is synchronous and clears all control state; the part RAM is not
//  cleared, since an entry is only read after it was written for the same
//  comparison. A held verdict stalls the request side only while it is not
//  being taken.

module version_number_compare
    import vnc_pkg::*;
#(
    parameter int unsigned MAX_PARTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_char_code,
    output logic                 o_stall,
    output logic                 o_valid,
    output logic [VERDICT_W-1:0] o_verdict,
    input  logic                 i_stall
);

    // address width of the part RAM and width of the part counters
    localparam int unsigned AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int unsigned CW = $clog2(MAX_PARTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTS);

    // control state
    t_state          r_state, n_state;
    logic            r_end, n_end;          // compare closes the second string
    logic [CW-1:0]   r_first_count, n_first_count;
    logic            r_nz_seen, n_nz_seen;
    logic [AW-1:0]   r_last_nz, n_last_nz;
    logic [PART_W-1:0] r_acc, n_acc;
    logic            r_digit, n_digit;
    logic [CW-1:0]   r_sidx, n_sidx;
    t_decision       r_decision, n_decision;
    logic            r_malformed, n_malformed;
    logic [1:0]      r_chars, n_chars;
    logic            r_phase, n_phase;
    logic            r_out_valid, n_out_valid;
    t_verdict        r_verdict, n_verdict;

    logic              in_acc;
    logic              is_digit;
    logic [PART_W+3:0] acc_next;
    logic              acc_ovf;
    logic              do_first;
    logic              do_clear;
    logic              ram_we;
    logic [PART_W-1:0] ram_rdata;
    logic [PART_W-1:0] ref_part;

    assign o_stall = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign in_acc  = i_valid && !o_stall;

    // accumulate one decimal digit: acc * 10 + digit as two shifts and two adds
    assign is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {{PART_W{1'b0}}, 4'(i_char_code - CHAR_ZERO)};
    assign acc_ovf  = acc_next > PART_LIMIT;

    // stored component for this place of the second string, zero beyond the first
    assign ref_part = (r_sidx < r_first_count) ? ram_rdata : '0;

    vnc_ram #(
        .WIDTH (PART_W),
        .DEPTH (MAX_PARTS)
    ) u_parts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_first_count[AW-1:0]),
        .i_wdata (r_acc),
        .i_raddr (r_sidx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_end         = r_end;
        n_first_count = r_first_count;
        n_nz_seen     = r_nz_seen;
        n_last_nz     = r_last_nz;
        n_acc         = r_acc;
        n_digit       = r_digit;
        n_sidx        = r_sidx;
        n_decision    = r_decision;
        n_malformed   = r_malformed;
        n_chars       = r_chars;
        n_phase       = r_phase;
        n_out_valid   = r_out_valid && i_stall;
        n_verdict     = r_verdict;
        do_first      = 1'b0;
        do_clear      = 1'b0;
        ram_we        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_op)) inside
                        OP_CHAR_FIRST, OP_CHAR_SECOND: begin
                            // drop characters of the string not being read
                            if (i_op[0] == r_phase) begin
                                n_chars[i_op[0]] = 1'b1;
                                if (i_char_code == CHAR_DOT) begin
                                    if (!r_phase) begin
                                        do_first = 1'b1;
                                    end else begin
                                        // RAM read is under way at r_sidx
                                        n_state = ST_CMP;
                                        n_end   = 1'b0;
                                    end
                                end else if (is_digit) begin
                                    if (!r_malformed) begin
                                        if (acc_ovf) begin
                                            n_malformed = 1'b1;
                                        end else begin
                                            n_acc = acc_next[PART_W-1:0];
                                        end
                                    end
                                    n_digit = 1'b1;
                                end else begin
                                    n_malformed = 1'b1;
                                end
                            end
                        end
                        OP_END_FIRST: begin
                            if (!r_phase) begin
                                do_first = r_chars[0];
                                n_acc    = '0;
                                n_digit  = 1'b0;
                                n_phase  = 1'b1;
                            end
                        end
                        OP_END_SECOND: begin
                            if (r_phase && r_chars[1]) begin
                                // close the last component before deciding
                                n_state = ST_CMP;
                                n_end   = 1'b1;
                            end else begin
                                // an empty second string, or an end that comes before the first string's end
                                n_out_valid = 1'b1;
                                n_verdict   = VERDICT_EMPTY;
                                do_clear    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CMP: begin
                n_state = ST_IDLE;
                if (!r_digit || (r_sidx >= MAX_CNT)) begin
                    n_malformed = 1'b1;
                end else begin
                    if (r_decision == DEC_NONE) begin
                        if (ref_part > r_acc) begin
                            n_decision = DEC_FIRST;
                        end else if (ref_part < r_acc) begin
                            n_decision = DEC_SECOND;
                        end
                    end
                    n_sidx = r_sidx + 1'b1;
                end
                n_acc   = '0;
                n_digit = 1'b0;
                if (r_end) begin
                    n_out_valid = 1'b1;
                    do_clear    = 1'b1;
                    if (!r_chars[0]) begin
                        n_verdict = VERDICT_EMPTY;
                    end else if (n_malformed) begin
                        n_verdict = VERDICT_MALFORMED;
                    end else if (n_decision == DEC_FIRST) begin
                        n_verdict = VERDICT_FIRST;
                    end else if (n_decision == DEC_SECOND) begin
                        n_verdict = VERDICT_SECOND;
                    end else if (r_nz_seen && (CW'(r_last_nz) >= n_sidx)) begin
                        // the first string has a nonzero component past the second's end
                        n_verdict = VERDICT_FIRST;
                    end else begin
                        n_verdict = VERDICT_EQUAL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // close a component of the first string and store it
        if (do_first) begin
            if (!r_digit || (r_first_count >= MAX_CNT)) begin
                n_malformed = 1'b1;
            end else begin
                ram_we = 1'b1;
                if (r_acc != '0) begin
                    n_nz_seen = 1'b1;
                    n_last_nz = r_first_count[AW-1:0];
                end
                n_first_count = r_first_count + 1'b1;
            end
            n_acc   = '0;
            n_digit = 1'b0;
        end

        // return to the reset state after a verdict
        if (do_clear) begin
            n_state       = ST_IDLE;
            n_first_count = '0;
            n_nz_seen     = 1'b0;
            n_last_nz     = '0;
            n_acc         = '0;
            n_digit       = 1'b0;
            n_sidx        = '0;
            n_decision    = DEC_NONE;
            n_malformed   = 1'b0;
            n_chars       = '0;
            n_phase       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_end         <= 1'b0;
            r_first_count <= '0;
            r_nz_seen     <= 1'b0;
            r_last_nz     <= '0;
            r_acc         <= '0;
            r_digit       <= 1'b0;
            r_sidx        <= '0;
            r_decision    <= DEC_NONE;
            r_malformed   <= 1'b0;
            r_chars       <= '0;
            r_phase       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_end         <= n_end;
            r_first_count <= n_first_count;
            r_nz_seen     <= n_nz_seen;
            r_last_nz     <= n_last_nz;
            r_acc         <= n_acc;
            r_digit       <= n_digit;
            r_sidx        <= n_sidx;
            r_decision    <= n_decision;
            r_malformed   <= n_malformed;
            r_chars       <= n_chars;
            r_phase       <= n_phase;
            r_out_valid   <= n_out_valid;
        end
    end

    // verdict payload needs no reset
    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

endmodule

### src/vnc_checker.sv
// Port-level assertions for the version number comparator, bound to the top level.
`timescale 1ns / 1ps

module vnc_checker
    import vnc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic [1:0]           i_op,
    input logic [7:0]           i_char_code,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic [VERDICT_W-1:0] o_verdict,
    input logic                 i_stall
);

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    // hold a stalled verdict
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_verdict))
        else $error("verdict dropped or changed while stalled");

    // only the end of the second string makes a verdict
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_valid && (i_op != OP_END_SECOND) |=> !o_valid)
        else $error("verdict without an end of second string");

    // after the end of the second string, either a verdict shows or requests stall
    a_end_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_valid && (i_op == OP_END_SECOND) |=> o_valid || o_stall)
        else $error("end of second string neither answered nor in progress");

endmodule

bind version_number_compare vnc_checker u_vnc_checker (.*);

### tb/sv/version_number_compare_tb.sv
// Self-checking testbench for the dotted version number comparator.
`timescale 1ns / 1ps

module version_number_compare_tb
    import vnc_pkg::*;
();

    localparam int unsigned MAX_PARTS = 16;
    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned DIRECTED_ROWS = 26;

    // One directed request; want is only meaningful when typed is set.
    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic       typed;
        t_verdict   want;
    } t_row;

    // Walk the special cases: verdict right after reset, requests out of turn,
    // zero and nine, both ends of the byte range, a trailing dot, a leading
    // dot, empty strings on either side and an end of the second string that
    // arrives before the end of the first.
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{OP_END_SECOND,  8'h00,     1'b1, VERDICT_EMPTY},
        '{OP_CHAR_FIRST,  CHAR_ZERO, 1'b0, VERDICT_EQUAL},
        '{OP_CHAR_SECOND, "5",       1'b0, VERDICT_EQUAL},
        '{OP_END_FIRST,   8'hA5,     1'b0, VERDICT_EQUAL},
        '{OP_CHAR_FIRST,  "7",       1'b0, VERDICT_EQUAL},
        '{OP_END_FIRST,   8'h5A,     1'b0, VERDICT_EQUAL},
        '{OP_CHAR_SECOND, CHAR_ZERO, 1'b0, VERDICT_EQUAL},
        '{OP_CHAR_SECOND, CHAR_DOT,  1'b0, VERDICT_EQUAL},
        '{OP_CHAR_SECOND, CHAR_NINE, 1'b0, VERDICT_EQUAL},
        '{OP_END_SECOND,  8'hFF,     1'b0, VERDICT_EQUAL},
        '{OP_CHAR_FIRST,  8'hFF,     1'b0, VERDICT_EQUAL},
        '{OP_END_FIRST,   8'h00,     1'b0, VERDICT_EQUAL},
        '{OP_CHAR_SECOND, 8'h00,     1'b0, VERDICT_EQUAL},
        '{OP_END_SECOND,  8'h00,     1'b1, VERDICT_MALFORMED},
        '{OP_CHAR_FIRST,  CHAR_NINE, 1'b0, VERDICT_EQUAL},
        '{OP_CHAR_FIRST,  CHAR_DOT,  1'b0, VERDICT_EQUAL},
        '{OP_END_FIRST,   8'h00,     1'b0, VERDICT_EQUAL},
        '{OP_CHAR_SECOND, CHAR_NINE, 1'b0, VERDICT_EQUAL},
        '{OP_END_SECOND,  8'h00,     1'b1, VERDICT_MALFORMED},
        '{OP_END_FIRST,   8'h00,     1'b0, VERDICT_EQUAL},
        '{OP_CHAR_SECOND, "1",       1'b0, VERDICT_EQUAL},
        '{OP_END_SECOND,  8'h00,     1'b1, VERDICT_EMPTY},
        '{OP_CHAR_FIRST,  CHAR_DOT,  1'b0, VERDICT_EQUAL},
        '{OP_END_FIRST,   8'h00,     1'b0, VERDICT_EQUAL},
        '{OP_END_SECOND,  8'h00,     1'b1, VERDICT_EMPTY},
        '{OP_CHAR_FIRST,  "3",       1'b0, VERDICT_EQUAL}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic [1:0]           i_op;
    logic [7:0]           i_char_code;
    logic                 o_stall;
    logic                 o_valid;
    logic [VERDICT_W-1:0] o_verdict;
    logic                 i_stall;

    // Comparator state as the predictor sees it.
    logic [PART_W-1:0] cmp_first_parts [MAX_PARTS];
    logic [4:0]        cmp_first_count;
    logic              cmp_nonzero;
    logic [3:0]        cmp_last_nz;
    logic [PART_W-1:0] cmp_acc;
    logic              cmp_digit;
    logic [4:0]        cmp_second_idx;
    t_decision         cmp_dec;
    logic              cmp_bad;
    logic [1:0]        cmp_seen;
    t_state            cmp_phase;

    t_verdict    verdicts_due [$];
    int unsigned failures = 0;
    int unsigned items_taken = 0;
    int unsigned snd_pct = 38;
    int unsigned rcv_pct = 55;
    int unsigned idle_stage = 0;
    bit          hold_req = 1'b0;
    bit          hold_issued = 1'b0;

    version_number_compare #(
        .MAX_PARTS(MAX_PARTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_char_code(i_char_code),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_verdict  (o_verdict),
        .i_stall    (i_stall)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Return the predictor to the state after reset; the stored parts are
    // only ever read after being written in the same comparison.
    task automatic reset_comparison();
        foreach (cmp_first_parts[k]) cmp_first_parts[k] = '0;
        cmp_first_count = '0;
        cmp_nonzero = 1'b0;
        cmp_last_nz = '0;
        cmp_acc = '0;
        cmp_digit = 1'b0;
        cmp_second_idx = '0;
        cmp_dec = DEC_NONE;
        cmp_bad = 1'b0;
        cmp_seen = '0;
        cmp_phase = ST_IDLE;
    endtask

    // Store a finished component of the first string and track the last
    // nonzero one for the trailing-component rule.
    task automatic close_first_part();
        if (!cmp_digit || cmp_first_count >= MAX_PARTS) begin
            cmp_bad = 1'b1;
        end else begin
            cmp_first_parts[cmp_first_count[3:0]] = cmp_acc;
            if (cmp_acc != '0) begin
                cmp_nonzero = 1'b1;
                cmp_last_nz = cmp_first_count[3:0];
            end
            cmp_first_count = cmp_first_count + 5'd1;
        end
        cmp_acc = '0;
        cmp_digit = 1'b0;
    endtask

    // Compare a finished component of the second string with the stored one
    // at the same place, or with zero past the end; the first difference wins.
    task automatic close_second_part();
        logic [PART_W-1:0] stored;
        if (!cmp_digit || cmp_second_idx >= MAX_PARTS) begin
            cmp_bad = 1'b1;
        end else begin
            stored = '0;
            if (cmp_second_idx < cmp_first_count) begin
                stored = cmp_first_parts[cmp_second_idx[3:0]];
            end
            if (cmp_dec == DEC_NONE) begin
                if (stored > cmp_acc) begin
                    cmp_dec = DEC_FIRST;
                end else if (stored < cmp_acc) begin
                    cmp_dec = DEC_SECOND;
                end
            end
            cmp_second_idx = cmp_second_idx + 5'd1;
        end
        cmp_acc = '0;
        cmp_digit = 1'b0;
    endtask

    // Advance the predictor by one accepted request. took drops for requests
    // out of turn; made rises only on the end of the second string.
    task automatic predict_verdict(input t_op op, input logic [7:0] ch,
                                   output bit took, output bit made,
                                   output t_verdict v);
        logic [PART_W+3:0] wide;
        took = 1'b1;
        made = 1'b0;
        v = VERDICT_EQUAL;
        case (op) inside
            OP_CHAR_FIRST, OP_CHAR_SECOND: begin
                if ((op == OP_CHAR_FIRST) != (cmp_phase == ST_IDLE)) begin
                    took = 1'b0;
                end else begin
                    cmp_seen[op == OP_CHAR_SECOND] = 1'b1;
                    if (ch == CHAR_DOT) begin
                        if (op == OP_CHAR_FIRST) begin
                            close_first_part();
                        end else begin
                            close_second_part();
                        end
                    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                        // Hold the component once it has overflowed.
                        if (!cmp_bad) begin
                            wide = {4'd0, cmp_acc} * 35'd10 + 35'(ch - CHAR_ZERO);
                            if (wide > PART_LIMIT) begin
                                cmp_bad = 1'b1;
                            end else begin
                                cmp_acc = wide[PART_W-1:0];
                            end
                        end
                        cmp_digit = 1'b1;
                    end else begin
                        cmp_bad = 1'b1;
                    end
                end
            end
            OP_END_FIRST: begin
                if (cmp_phase != ST_IDLE) begin
                    took = 1'b0;
                end else begin
                    if (cmp_seen[0]) begin
                        close_first_part();
                    end
                    cmp_acc = '0;
                    cmp_digit = 1'b0;
                    cmp_phase = ST_CMP;
                end
            end
            default: begin
                made = 1'b1;
                if (cmp_phase == ST_IDLE) begin
                    v = VERDICT_EMPTY;
                end else begin
                    if (cmp_seen[1]) begin
                        close_second_part();
                    end
                    // Empty outranks malformed, malformed outranks any order.
                    if (cmp_seen != 2'b11) begin
                        v = VERDICT_EMPTY;
                    end else if (cmp_bad) begin
                        v = VERDICT_MALFORMED;
                    end else if (cmp_dec == DEC_FIRST) begin
                        v = VERDICT_FIRST;
                    end else if (cmp_dec == DEC_SECOND) begin
                        v = VERDICT_SECOND;
                    end else if (cmp_nonzero && {1'b0, cmp_last_nz} >= cmp_second_idx) begin
                        v = VERDICT_FIRST;
                    end else begin
                        v = VERDICT_EQUAL;
                    end
                end
                reset_comparison();
            end
        endcase
    endtask

    // Offer one request after a random gap, hold it until it is taken, then
    // advance the predictor and queue the verdict it calls for.
    task automatic drive_request(input t_op op, input logic [7:0] ch,
                                 input bit typed, input t_verdict want);
        bit       took;
        bit       made;
        t_verdict v;
        while ($urandom_range(0, 99) < snd_pct) begin
            i_valid <= 1'b0;
            i_op <= 2'($urandom_range(0, 3));
            i_char_code <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_char_code <= ch;
        // Inputs only move at the rising edge, so the stall seen at the
        // falling edge is the one the block acts on.
        do @(negedge i_clk); while (o_stall !== 1'b0);
        @(posedge i_clk);
        predict_verdict(op, ch, took, made, v);
        if (took) begin
            items_taken++;
        end
        if (made) begin
            verdicts_due = {verdicts_due, (typed ? want : v)};
        end
    endtask

    // Drop valid and wait until every queued verdict has come back.
    task automatic drain_verdicts();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic longint unsigned pick_part();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return longint'($urandom_range(0, 9));
        if (r < 60) return longint'($urandom_range(10, 999));
        if (r < 72) return 0;
        if (r < 82) return PART_LIMIT - $urandom_range(0, 9);
        if (r < 90) return {32'd0, $urandom()};
        if (r < 97) return PART_LIMIT + 64'd1 + $urandom_range(0, 9);
        return {$urandom(), $urandom()};
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 4);
        if (r < 90) return $urandom_range(5, MAX_PARTS);
        if (r < 96) return MAX_PARTS;
        return MAX_PARTS + 1;
    endfunction

    // Spell the components out in decimal, with a leading zero now and then.
    task automatic spell_version(input longint unsigned parts [$],
                                 output logic [7:0] text [$]);
        logic [7:0]        digits [$];
        longint unsigned   left;
        text = {};
        foreach (parts[k]) begin
            if (k != 0) begin
                text = {text, CHAR_DOT};
            end
            digits = {};
            left = parts[k];
            do begin
                digits.push_front(CHAR_ZERO + 8'(left % 10));
                left = left / 10;
            end while (left != 0);
            if ($urandom_range(0, 9) == 0) begin
                digits.push_front(CHAR_ZERO);
            end
            text = {text, digits};
        end
    endtask

    // Break a well-formed string: drop or insert a byte, insert or trail a
    // dot, or empty it out.
    task automatic damage_version(inout logic [7:0] text [$]);
        case ($urandom_range(0, 4))
            0: if (text.size() != 0) text.delete($urandom_range(0, text.size() - 1));
            1: text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
            2: text.insert($urandom_range(0, text.size()), CHAR_DOT);
            3: text = {};
            default: text = {text, CHAR_DOT};
        endcase
    endtask

    // One full comparison. The second string is mostly built from the first
    // so that equal prefixes, trailing zeros and single differences are common.
    task automatic run_comparison();
        longint unsigned first_val [$];
        longint unsigned second_val [$];
        logic [7:0]      first_text [$];
        logic [7:0]      second_text [$];
        int unsigned     n;
        n = pick_count();
        first_val = {};
        repeat (n) first_val = {first_val, pick_part()};
        second_val = first_val;
        case ($urandom_range(0, 5))
            0: ;
            1: repeat ($urandom_range(1, 3)) second_val = {second_val, 64'd0};
            2: second_val[$urandom_range(0, n - 1)] = pick_part();
            3: begin
                second_val = {};
                repeat (pick_count()) second_val = {second_val, pick_part()};
            end
            4: repeat ($urandom_range(0, n - 1)) void'(second_val.pop_back());
            default: begin
                second_val[$urandom_range(0, n - 1)] = pick_part();
                second_val = {second_val, 64'($urandom_range(0, 1))};
            end
        endcase
        spell_version(first_val, first_text);
        spell_version(second_val, second_text);
        if ($urandom_range(0, 99) < 8) damage_version(first_text);
        if ($urandom_range(0, 99) < 8) damage_version(second_text);

        foreach (first_text[k]) begin
            // Slip in a second-string character that must be ignored.
            if ($urandom_range(0, 99) < 3) begin
                drive_request(OP_CHAR_SECOND, 8'($urandom_range(0, 255)), 1'b0, VERDICT_EQUAL);
            end
            drive_request(OP_CHAR_FIRST, first_text[k], 1'b0, VERDICT_EQUAL);
        end
        // Now and then end the second string before the first has ended.
        if ($urandom_range(0, 99) < 3) begin
            drive_request(OP_END_SECOND, 8'($urandom_range(0, 255)), 1'b0, VERDICT_EQUAL);
        end else begin
            drive_request(OP_END_FIRST, 8'($urandom_range(0, 255)), 1'b0, VERDICT_EQUAL);
            foreach (second_text[k]) begin
                if ($urandom_range(0, 99) < 3) begin
                    drive_request($urandom_range(0, 1) ? OP_END_FIRST : OP_CHAR_FIRST,
                                  8'($urandom_range(0, 255)), 1'b0, VERDICT_EQUAL);
                end
                drive_request(OP_CHAR_SECOND, second_text[k], 1'b0, VERDICT_EQUAL);
            end
            drive_request(OP_END_SECOND, 8'($urandom_range(0, 255)), 1'b0, VERDICT_EQUAL);
        end
    endtask

    initial begin : request_source
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op <= OP_CHAR_FIRST;
        i_char_code <= 8'h00;
        reset_comparison();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[row]) begin
            drive_request(DIRECTED[row].op, DIRECTED[row].ch,
                          DIRECTED[row].typed, DIRECTED[row].want);
        end
        items_taken = 0;

        while (items_taken < RANDOM_ITEMS) begin
            // Swap idling roles after a third, stop idling after two thirds;
            // pause on each switch until every verdict is back.
            if (items_taken * 3 / RANDOM_ITEMS != idle_stage) begin
                drain_verdicts();
                idle_stage = items_taken * 3 / RANDOM_ITEMS;
                snd_pct = (idle_stage == 1) ? 55 : 0;
                rcv_pct = (idle_stage == 1) ? 38 : 0;
            end
            // Ask the sink for a long hold-off while requests keep coming.
            if (!hold_issued && items_taken >= 150) begin
                hold_issued = 1'b1;
                hold_req = 1'b1;
            end
            run_comparison();
        end

        drain_verdicts();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Drive the verdict stall: random stalls, plus one long hold-off that
    // backs the block up into its request side.
    initial begin : verdict_sink
        int unsigned hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (i_rst_n === 1'b1) && ($urandom_range(0, 99) < rcv_pct);
            end
        end
    end

    // Check each verdict taken at the next rising edge against the oldest
    // expectation.
    always @(negedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual %0d",
                         $time, o_verdict);
                failures++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_verdict !== want) begin
                    $display("%0t: verdict mismatch, expected %0d (%s), actual %0d",
                             $time, want, want.name(), o_verdict);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
src/vnc_pkg.sv
src/vnc_ram.sv
src/version_number_compare.sv
src/vnc_checker.sv
tb/sv/version_number_compare_tb.sv
